// File: src/rgb_to_hsv_pixel_macros.svh
// Assertion macros shared by the RGB to HSV pixel converter.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rhp_pkg.sv
// Shared types and constants of the RGB to HSV pixel converter.
`default_nettype none

package rhp_pkg;

  localparam int ChanW  = 8;   // input channel width
  localparam int QuoW   = 16;  // quotient width of both dividers
  localparam int HueDivW = 11; // width of 6 * (max - min)

  // Work item carried from the front end through the queue and the divider pipe.
  typedef struct packed {
    logic [ChanW-1:0]   brightness; // max channel, also saturation divisor
    logic [ChanW-1:0]   sat_rem;    // saturation partial remainder
    logic               sat_bit;    // next dividend bit for saturation
    logic [QuoW-1:0]    sat_q;      // saturation quotient so far
    logic [HueDivW-1:0] hue_rem;    // hue partial remainder
    logic [HueDivW-1:0] hue_div;    // 6 * (max - min)
    logic [QuoW-1:0]    hue_q;      // hue quotient so far
    logic               black;      // max == 0
    logic               gray;       // max == min
  } pipe_t;

  // Finished result.
  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic [QuoW-1:0]  saturation;
    logic [QuoW-1:0]  hue;
  } res_t;

endpackage

`default_nettype wire

// File: src/rhp_front.sv
// Front end: takes a pixel, finds max, min, hue sector and divider operands.
`default_nettype none

module rhp_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            red,
  input  wire logic [7:0]            green,
  input  wire logic [7:0]            blue,
  output logic                       item_valid,
  input  wire logic                  item_ready,
  output rhp_pkg::pipe_t             item
);
  import rhp_pkg::*;

  logic                  valid_r;
  pipe_t                 item_r;
  pipe_t                 item_nxt;

  logic [ChanW-1:0]      vmax;
  logic [ChanW-1:0]      vmin;
  logic [ChanW-1:0]      diff;
  logic [HueDivW-1:0]    d6;
  logic [HueDivW:0]      num;
  logic [HueDivW:0]      r_x;
  logic [HueDivW:0]      g_x;
  logic [HueDivW:0]      b_x;
  logic [HueDivW:0]      d_x;

  always_comb begin
    r_x = {{(HueDivW+1-ChanW){1'b0}}, red};
    g_x = {{(HueDivW+1-ChanW){1'b0}}, green};
    b_x = {{(HueDivW+1-ChanW){1'b0}}, blue};

    // min of three, ties irrelevant
    vmin = (red < green) ? red : green;
    if (blue < vmin) begin
      vmin = blue;
    end

    // max with red winning ties, then green
    if (red >= green && red >= blue) begin
      vmax = red;
    end else if (green >= blue) begin
      vmax = green;
    end else begin
      vmax = blue;
    end

    diff = vmax - vmin;
    d_x  = {{(HueDivW+1-ChanW){1'b0}}, diff};
    d6   = HueDivW'({d_x, 2'b00}) + HueDivW'({d_x, 1'b0});

    // sector numerator, modulo 2^12; only the red sector can go negative
    if (red >= green && red >= blue) begin
      num = g_x - b_x;
      if (num[HueDivW]) begin
        num = num + {1'b0, d6};
      end
    end else if (green >= blue) begin
      num = b_x - r_x + {d_x[HueDivW-1:0], 1'b0};
    end else begin
      num = r_x - g_x + {d_x[HueDivW-2:0], 2'b00};
    end

    item_nxt.brightness = vmax;
    item_nxt.sat_rem    = {1'b0, diff[ChanW-1:1]};
    item_nxt.sat_bit    = diff[0];
    item_nxt.sat_q      = '0;
    item_nxt.hue_rem    = num[HueDivW-1:0];
    item_nxt.hue_div    = d6;
    item_nxt.hue_q      = '0;
    item_nxt.black      = (vmax == '0);
    item_nxt.gray       = (diff == '0);
  end

  assign in_ready = !valid_r || item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: src/rhp_queue.sv
// Two-entry queue between the front end and the divider pipe.
`default_nettype none

module rhp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire rhp_pkg::pipe_t wr_item,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output rhp_pkg::pipe_t      rd_item
);
  import rhp_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  pipe_t             entry_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   count_nxt;
  logic              push;
  logic              pop;

  assign wr_ready = (count_r != CntW'(Depth));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: src/rhp_back.sv
// Back end: pipelined restoring dividers for saturation and hue, one bit a stage.
`default_nettype none

module rhp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire rhp_pkg::pipe_t item,
  output logic                res_valid,
  input  wire logic           res_ready,
  output rhp_pkg::res_t       res
);
  import rhp_pkg::*;

  localparam int NStg = QuoW;

  pipe_t             st_r [NStg];
  logic [NStg-1:0]   v_r;
  logic              adv;

  // one quotient bit of each divider
  function automatic pipe_t div_step(input pipe_t s);
    pipe_t              n;
    logic [ChanW:0]     st;
    logic [HueDivW:0]   ht;
    n  = s;
    st = {s.sat_rem, s.sat_bit};
    n.sat_bit = 1'b0;
    if (st >= {1'b0, s.brightness}) begin
      n.sat_rem = ChanW'(st - {1'b0, s.brightness});
      n.sat_q   = {s.sat_q[QuoW-2:0], 1'b1};
    end else begin
      n.sat_rem = st[ChanW-1:0];
      n.sat_q   = {s.sat_q[QuoW-2:0], 1'b0};
    end
    ht = {s.hue_rem, 1'b0};
    if (ht >= {1'b0, s.hue_div}) begin
      n.hue_rem = HueDivW'(ht - {1'b0, s.hue_div});
      n.hue_q   = {s.hue_q[QuoW-2:0], 1'b1};
    end else begin
      n.hue_rem = ht[HueDivW-1:0];
      n.hue_q   = {s.hue_q[QuoW-2:0], 1'b0};
    end
    return n;
  endfunction

  // whole pipe moves unless the last stage holds a result nobody takes
  assign adv        = !v_r[NStg-1] || res_ready;
  assign item_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NStg-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_step(item);
      for (int k = 1; k < NStg; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign res_valid      = v_r[NStg-1];
  assign res.brightness = st_r[NStg-1].brightness;
  assign res.saturation = st_r[NStg-1].black ? '0 : st_r[NStg-1].sat_q;
  assign res.hue        = st_r[NStg-1].gray ? '0 : st_r[NStg-1].hue_q;

endmodule

`default_nettype wire

// File: src/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter: stream in, stream out.
//
// Usage:
//   Input channel in_*: one RGB pixel per request, 8-bit channels in in_tdata.
//   Output channel out_*: one HSV result per pixel, in order.
//     hue        - fraction of a full turn, Q0.16, truncated, wraps
//     saturation - (max-min)/max, Q1.15, 0x8000 means one, 0 for black
//     brightness - the largest input channel
//   Gray pixels (max == min) give hue 0.
// Path: an accepted input passes the front register, one queue slot and the
//   16 divider stages on its way to out_tvalid.
// Throughput: one pixel per clock, sustained while out_tready stays high, set by the
//   16-stage divider pipe that retires one quotient bit of both dividers per stage.
// Stalls: a two-entry queue sits between the front end and the divider pipe.
//   When out_tready is low and the last stage holds a result, the divider pipe freezes;
//   the queue and front register keep taking requests until they fill, then in_tready drops.
// Reset: rst_n low (sync) empties the front register, queue and pipe.
`default_nettype none

`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [15:0] hue, [31:16] saturation, [39:32] brightness
);
  import rhp_pkg::*;

  logic  fr_valid;
  logic  fr_ready;
  pipe_t fr_item;
  logic  qu_valid;
  logic  qu_ready;
  pipe_t qu_item;
  res_t  res;

  rhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .red        (in_tdata[7:0]),
    .green      (in_tdata[15:8]),
    .blue       (in_tdata[23:16]),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  rhp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (qu_valid),
    .rd_ready (qu_ready),
    .rd_item  (qu_item)
  );

  rhp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (qu_valid),
    .item_ready (qu_ready),
    .item       (qu_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.brightness, res.saturation, res.hue};

  // black pixel must come out with zero hue and saturation
  `RHP_ASSERT_NOW(a_black_zero, clk, rst_n, out_tvalid && out_tdata[39:32] == 8'd0, out_tdata[31:0] == 32'd0, "black pixel with nonzero hue or saturation")
  // saturation never exceeds one
  `RHP_ASSERT_NOW(a_sat_range, clk, rst_n, out_tvalid, out_tdata[31:16] <= 16'h8000, "saturation above one")
  // input back-pressure only when the front register holds a stalled item
  `RHP_ASSERT_NOW(a_front_stall, clk, rst_n, !in_tready, fr_valid && !fr_ready, "input stalled with room in front end")
  // an accepted request always lands in the front register
  `RHP_ASSERT_NEXT(a_front_load, clk, rst_n, in_tvalid && in_tready, fr_valid, "accepted request lost at front end")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking stream testbench for the rgb_to_hsv_pixel converter.
`timescale 1ns / 100ps

module tb_top;
  import rhp_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam int unsigned DrainCycles = 60;     // well past the converter latency
  localparam int unsigned HoldCycles  = 400;    // long receiver hold-off

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // [7:0] red, [15:8] green, [23:16] blue
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [15:0] hue, [31:16] saturation, [39:32] brightness

  pixel_t      pending_px[$];     // pixels not yet offered
  res_t        expected_hsv[$];   // HSV results owed by the converter
  pixel_t      cur_px;            // pixel currently on the input bus
  int unsigned err_cnt = 0;
  int unsigned n_recv = 0;
  int unsigned cyc = 0;           // free-running cycle count, NBA updated
  logic        rx_hold = 1'b0;    // receiver is in its long hold-off

  rgb_to_hsv_pixel u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // HSV of one pixel: value = max, saturation = d/max in Q1.15, hue in turns Q0.16.
  function automatic res_t hsv_of(input pixel_t px);
    logic [7:0]        hi, lo;
    int unsigned       d;
    int                num;
    longint unsigned   n64;
    longint unsigned   q;
    res_t              res;
    hi = px.red;
    if (px.green > hi) hi = px.green;
    if (px.blue > hi) hi = px.blue;
    lo = px.red;
    if (px.green < lo) lo = px.green;
    if (px.blue < lo) lo = px.blue;
    d = 32'(hi - lo);
    res = '0;
    res.brightness = hi;
    if (hi != 0) res.saturation = 16'((d << 15) / hi);   // black stays 0
    if (d != 0) begin                                     // gray keeps hue 0
      // ties resolve red first, then green
      if (hi == px.red) num = int'(px.green) - int'(px.blue);
      else if (hi == px.green) num = int'(px.blue) - int'(px.red) + 2 * int'(d);
      else num = int'(px.red) - int'(px.green) + 4 * int'(d);
      if (num < 0) num = num + 6 * int'(d);
      n64 = longint'(num);
      q = (n64 << 16) / (64'(6) * 64'(d));
      res.hue = q[15:0];
    end
    return res;
  endfunction

  // Idle length: mostly short, a few long; zero inside a quiet stretch.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < 100)
      $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", n_recv, what, got, want);
    err_cnt++;
  endtask

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    pending_px.push_back(px);
  endtask

  // Random pixel, biased toward ties, grays, narrow spreads and rail values.
  task automatic push_random_pixel();
    int unsigned kind;
    logic [7:0]  v, w;
    logic [7:0]  ch[3];
    kind = $urandom_range(0, 9);
    v = 8'($urandom_range(0, 255));
    w = 8'($urandom_range(0, 32'(v)));
    case (kind)
      6: begin
        push_pixel(v, v, v);
      end
      7: begin
        case ($urandom_range(0, 2))
          0: push_pixel(v, v, w);
          1: push_pixel(w, v, v);
          default: push_pixel(v, w, v);
        endcase
      end
      8: begin
        for (int i = 0; i < 3; i++) ch[i] = (v > 252) ? 8'(v - $urandom_range(0, 2))
                                                      : 8'(v + $urandom_range(0, 2));
        push_pixel(ch[0], ch[1], ch[2]);
      end
      9: begin
        for (int i = 0; i < 3; i++)
          case ($urandom_range(0, 2))
            0: ch[i] = 8'd0;
            1: ch[i] = 8'd255;
            default: ch[i] = 8'($urandom_range(0, 255));
          endcase
        push_pixel(ch[0], ch[1], ch[2]);
      end
      default: begin
        push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Driver: one request per handshake, new pixel loaded only when the bus is free.
  int unsigned tx_gap = 0;
  logic        tx_valid_nxt;
  logic [23:0] tx_data_nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) expected_hsv.push_back(hsv_of(cur_px));
      if (!(in_tvalid && !in_tready)) begin
        tx_valid_nxt = 1'b0;
        tx_data_nxt  = in_tdata;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_px.size() > 0) begin
          cur_px = pending_px.pop_front();
          tx_valid_nxt = 1'b1;
          tx_data_nxt  = {cur_px.blue, cur_px.green, cur_px.red};
          // keep offering back to back while the receiver holds off or in a quiet stretch
          tx_gap = pick_gap(rx_hold || ((cyc / 150) % 4 == 1));
        end
        in_tvalid <= tx_valid_nxt;
        in_tdata  <= tx_data_nxt;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation, drives out_tready.
  int unsigned rx_gap = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done_a = 1'b0;
  bit          hold_done_b = 1'b0;
  res_t        got_hsv;
  res_t        want_hsv;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_hsv = out_tdata;
        if (expected_hsv.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_tdata), 0);
        end else begin
          want_hsv = expected_hsv.pop_front();
          if (got_hsv.hue !== want_hsv.hue)
            report_mismatch("hue", 32'(got_hsv.hue), 32'(want_hsv.hue));
          if (got_hsv.saturation !== want_hsv.saturation)
            report_mismatch("saturation", 32'(got_hsv.saturation),
                            32'(want_hsv.saturation));
          if (got_hsv.brightness !== want_hsv.brightness)
            report_mismatch("brightness", 32'(got_hsv.brightness),
                            32'(want_hsv.brightness));
        end
        n_recv++;
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_gap = pick_gap((cyc / 170) % 4 == 2);
      end
    end
  end

  // Receiver hold-off, counted in cycles: two long ones so the queue and pipe
  // back up into in_tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt = 0;
      rx_hold <= 1'b0;
    end else begin
      if (!hold_done_a && n_recv >= 300) begin
        hold_done_a = 1'b1;
        hold_cnt = HoldCycles;
      end
      if (!hold_done_b && n_recv >= 900) begin
        hold_done_b = 1'b1;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rx_hold <= 1'b1;
      end else begin
        rx_hold <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    // directed: rails, grays, each sector, ties, smallest spreads
    push_pixel(8'd0,   8'd0,   8'd0);     // black
    push_pixel(8'd255, 8'd255, 8'd255);   // white
    push_pixel(8'd128, 8'd128, 8'd128);   // mid gray
    push_pixel(8'd1,   8'd1,   8'd1);     // darkest gray
    push_pixel(8'd255, 8'd0,   8'd0);     // pure red
    push_pixel(8'd0,   8'd255, 8'd0);     // pure green
    push_pixel(8'd0,   8'd0,   8'd255);   // pure blue
    push_pixel(8'd255, 8'd0,   8'd1);     // red sector, wraps negative
    push_pixel(8'd255, 8'd0,   8'd254);   // red sector, deep wrap
    push_pixel(8'd255, 8'd254, 8'd0);     // red sector, positive
    push_pixel(8'd255, 8'd255, 8'd0);     // red/green tie
    push_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie
    push_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie
    push_pixel(8'd10,  8'd200, 8'd50);    // green sector
    push_pixel(8'd50,  8'd10,  8'd200);   // blue sector
    push_pixel(8'd1,   8'd0,   8'd0);     // max 1, d 1
    push_pixel(8'd0,   8'd1,   8'd0);
    push_pixel(8'd0,   8'd0,   8'd1);
    push_pixel(8'd255, 8'd254, 8'd254);   // smallest spread at top
    push_pixel(8'd254, 8'd255, 8'd254);
    push_pixel(8'd254, 8'd254, 8'd255);
    push_pixel(8'hAA,  8'h55,  8'hAA);    // alternating bit patterns
    push_pixel(8'h55,  8'hAA,  8'h55);
    push_pixel(8'd0,   8'd255, 8'd128);
    for (int i = 0; i < 1300; i++) push_random_pixel();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_px.size() != 0 || in_tvalid || expected_hsv.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_hsv.size() != 0)
      report_mismatch("missing results", expected_hsv.size(), 0);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/rhp_pkg.sv
src/rhp_front.sv
src/rhp_queue.sv
src/rhp_back.sv
src/rgb_to_hsv_pixel.sv
bench/tb_top.sv
